/* src/atf_pkg.sv */
// Package for the accelerometer tilt-angle filter.
// Holds widths, the CORDIC arctangent table and the shared command/status structs.
// No dependencies.
package atf_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TAB_LEN      = 24;
    localparam int CW           = 42;   // CORDIC x/y width
    localparam int AW           = 26;   // angle accumulator width, degrees Q16
    localparam int SW           = 22;   // filtered value width
    localparam int SQW          = 60;   // square-root radicand width
    localparam int RW           = 30;   // root width
    localparam int ROLL_MAX     = 23040;
    localparam int PITCH_MAX    = 11520;
    localparam int DEG90        = 5898240;

    function automatic logic [AW-1:0] atan_tab(input logic [4:0] i);
        logic [AW-1:0] v;
        begin
            case (i)
                5'd0:  v = AW'(2949120);
                5'd1:  v = AW'(1740967);
                5'd2:  v = AW'(919879);
                5'd3:  v = AW'(466945);
                5'd4:  v = AW'(234379);
                5'd5:  v = AW'(117304);
                5'd6:  v = AW'(58666);
                5'd7:  v = AW'(29335);
                5'd8:  v = AW'(14668);
                5'd9:  v = AW'(7334);
                5'd10: v = AW'(3667);
                5'd11: v = AW'(1833);
                5'd12: v = AW'(917);
                5'd13: v = AW'(458);
                5'd14: v = AW'(229);
                5'd15: v = AW'(115);
                5'd16: v = AW'(57);
                5'd17: v = AW'(29);
                5'd18: v = AW'(14);
                5'd19: v = AW'(7);
                5'd20: v = AW'(4);
                5'd21: v = AW'(2);
                5'd22: v = AW'(1);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

    // controller to datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic filt;      // filter step on axis filt_ax
        logic [1:0] filt_ax;
        logic sq_x;      // square fx
        logic sq_z;      // square fz, sum
        logic sqrt_init;
        logic sqrt_step;
        logic roll_init;
        logic pitch_init;
        logic cor_step;
        logic roll_done;
        logic pitch_done;
        logic out_load;
        logic out_zero;
    } atf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sqrt_last;
        logic cor_last;
        logic new_data;
    } atf_sts_t;

endpackage

/* src/atf_datapath.sv */
// Datapath for the tilt-angle filter: low-pass filter, square root, CORDIC.
// Depends on atf_pkg; driven by atf_ctrl commands.
module atf_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [15:0]            filter_weight,
    input  logic [7:0]             status,
    input  logic [15:0]            x_word,
    input  logic [15:0]            y_word,
    input  logic [15:0]            z_word,
    input  atf_pkg::atf_cmd_t      cmd,
    output atf_pkg::atf_sts_t      sts,
    output logic                   o_valid_res,
    output logic signed [21:0]     o_fx,
    output logic signed [21:0]     o_fy,
    output logic signed [21:0]     o_fz,
    output logic signed [15:0]     o_roll,
    output logic signed [14:0]     o_pitch
);
    import atf_pkg::*;

    logic              nd_reg;
    logic signed [13:0] cx_reg, cy_reg, cz_reg;
    logic signed [SW-1:0] sx_reg, sy_reg, sz_reg;
    logic signed [SQW-1:0] sq_reg;
    logic [SQW-1:0]    rem_reg;
    logic [RW-1:0]     root_reg;
    logic [4:0]        sqi_reg;
    logic signed [CW-1:0] cx_c_reg, cy_c_reg;
    logic signed [AW-1:0] acc_reg;
    logic              zero_reg;
    logic [4:0]        ci_reg;
    logic signed [15:0] roll_reg;
    logic signed [14:0] pitch_reg;

    // filter: select axis
    logic signed [SW-1:0] f_prev;
    logic signed [13:0]   f_cnt;
    logic signed [40:0]   f_sum;
    logic signed [SW-1:0] f_new;
    always_comb
    begin
        case (cmd.filt_ax)
            2'd0:    begin f_prev = sx_reg; f_cnt = cx_reg; end
            2'd1:    begin f_prev = sy_reg; f_cnt = cy_reg; end
            default: begin f_prev = sz_reg; f_cnt = cz_reg; end
        endcase
        f_sum = 41'(f_prev) * $signed({25'd0, filter_weight})
              + 41'(f_cnt) * 41'sd256 * $signed(41'(17'h10000 - {1'b0, filter_weight}))
              + 41'sd32768;
        f_new = f_sum[16 +: SW];
    end

    // square root: two bits a step
    logic [RW+1:0] s_test;
    logic [SQW+1:0] s_rem2;
    always_comb
    begin
        s_rem2 = {rem_reg, sq_reg[SQW-1 -: 2]};
        s_test = {root_reg, 2'b01};
    end

    // CORDIC step
    logic signed [CW-1:0] dx, dy;
    logic signed [CW-1:0] px, py;
    logic signed [AW-1:0] pz;
    always_comb
    begin
        dx = cx_c_reg >>> ci_reg;
        dy = cy_c_reg >>> ci_reg;
        if (!cy_c_reg[CW-1])
        begin
            px = cx_c_reg + dy;
            py = cy_c_reg - dx;
            pz = acc_reg + $signed(atan_tab(ci_reg));
        end
        else
        begin
            px = cx_c_reg - dy;
            py = cy_c_reg + dx;
            pz = acc_reg - $signed(atan_tab(ci_reg));
        end
    end

    // CORDIC init operands
    logic signed [CW-1:0] iy, ix;
    always_comb
    begin
        if (cmd.roll_init)
        begin
            iy = CW'(sx_reg) <<< 8;
            ix = CW'(sz_reg) <<< 8;
        end
        else
        begin
            iy = -(CW'(sy_reg) <<< 8);
            ix = $signed(CW'(root_reg));
        end
    end

    // final angle with rounding
    logic signed [AW-1:0] a_rnd;
    logic signed [AW-10:0] a_q;
    always_comb
    begin
        a_rnd = acc_reg + AW'(256);
        a_q   = a_rnd[AW-1:9];
    end

    assign sts.sqrt_last = (sqi_reg == 5'd0);
    assign sts.cor_last  = (ci_reg == 5'(CORDIC_STEPS - 1));
    assign sts.new_data  = nd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0;
            sy_reg <= '0;
            sz_reg <= '0;
            nd_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
                nd_reg <= (status[3:0] != 4'd0);
            if (cmd.filt)
            begin
                case (cmd.filt_ax)
                    2'd0:    sx_reg <= f_new;
                    2'd1:    sy_reg <= f_new;
                    default: sz_reg <= f_new;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // capture counts
        if (cmd.load)
        begin
            cx_reg <= x_word[15:2];
            cy_reg <= y_word[15:2];
            cz_reg <= z_word[15:2];
        end
        // sum of squares, shifted by 16
        if (cmd.sq_x)
            sq_reg <= SQW'(sx_reg * sx_reg);
        if (cmd.sq_z)
            sq_reg <= (sq_reg + SQW'(sz_reg * sz_reg)) <<< 16;
        if (cmd.sqrt_init)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            sqi_reg  <= 5'(RW - 1);
        end
        if (cmd.sqrt_step)
        begin
            sq_reg  <= sq_reg <<< 2;
            sqi_reg <= sqi_reg - 5'd1;
            if (s_rem2 >= (SQW+2)'(s_test))
            begin
                rem_reg  <= SQW'(s_rem2 - (SQW+2)'(s_test));
                root_reg <= {root_reg[RW-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= SQW'(s_rem2);
                root_reg <= {root_reg[RW-2:0], 1'b0};
            end
        end
        // CORDIC
        if (cmd.roll_init || cmd.pitch_init)
        begin
            ci_reg   <= '0;
            zero_reg <= (ix == 0) && (iy == 0);
            if (ix[CW-1])
            begin
                if (!iy[CW-1])
                begin
                    cx_c_reg <= iy;
                    cy_c_reg <= -ix;
                    acc_reg  <= AW'(DEG90);
                end
                else
                begin
                    cx_c_reg <= -iy;
                    cy_c_reg <= ix;
                    acc_reg  <= -AW'(DEG90);
                end
            end
            else
            begin
                cx_c_reg <= ix;
                cy_c_reg <= iy;
                acc_reg  <= '0;
            end
        end
        if (cmd.cor_step)
        begin
            cx_c_reg <= px;
            cy_c_reg <= py;
            acc_reg  <= pz;
            ci_reg   <= ci_reg + 5'd1;
        end
        if (cmd.roll_done)
        begin
            if (zero_reg)
                roll_reg <= '0;
            else if (a_q > ROLL_MAX)
                roll_reg <= 16'(ROLL_MAX);
            else if (a_q < -ROLL_MAX)
                roll_reg <= -16'(ROLL_MAX);
            else
                roll_reg <= 16'(a_q);
        end
        if (cmd.pitch_done)
        begin
            if (zero_reg)
                pitch_reg <= '0;
            else if (a_q > PITCH_MAX)
                pitch_reg <= 15'(PITCH_MAX);
            else if (a_q < -PITCH_MAX)
                pitch_reg <= -15'(PITCH_MAX);
            else
                pitch_reg <= 15'(a_q);
        end
        // result register
        if (cmd.out_load)
        begin
            o_valid_res <= 1'b1;
            o_fx        <= sx_reg;
            o_fy        <= sy_reg;
            o_fz        <= sz_reg;
            o_roll      <= roll_reg;
            o_pitch     <= pitch_reg;
        end
        if (cmd.out_zero)
        begin
            o_valid_res <= 1'b0;
            o_fx        <= '0;
            o_fy        <= '0;
            o_fz        <= '0;
            o_roll      <= '0;
            o_pitch     <= '0;
        end
    end

endmodule

/* src/atf_ctrl.sv */
// Controller state machine for the tilt-angle filter.
// Depends on atf_pkg; sequences atf_datapath through commands.
module atf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    input  atf_pkg::atf_sts_t sts,
    output atf_pkg::atf_cmd_t cmd
);
    import atf_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_CHK    = 12'b000000000010,
        S_FILT   = 12'b000000000100,
        S_SQX    = 12'b000000001000,
        S_SQZ    = 12'b000000010000,
        S_SQRT   = 12'b000000100000,
        S_RINIT  = 12'b000001000000,
        S_RSTEP  = 12'b000010000000,
        S_PINIT  = 12'b000100000000,
        S_PSTEP  = 12'b001000000000,
        S_OUT    = 12'b010000000000,
        S_HOLD   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] ax_reg, ax_next;
    logic ov_reg, ov_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ax_next    = ax_reg;
        ov_next    = ov_reg;
        cmd        = '0;
        cmd.filt_ax = ax_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                ax_next = 2'd0;
                if (sts.new_data)
                    state_next = S_FILT;
                else
                begin
                    cmd.out_zero = 1'b1;
                    ov_next      = 1'b1;
                    state_next   = S_HOLD;
                end
            end
            S_FILT:
            begin
                cmd.filt = 1'b1;
                ax_next  = ax_reg + 2'd1;
                if (ax_reg == 2'd2)
                    state_next = S_SQX;
            end
            S_SQX:
            begin
                cmd.sq_x   = 1'b1;
                state_next = S_SQZ;
            end
            S_SQZ:
            begin
                cmd.sq_z      = 1'b1;
                cmd.sqrt_init = 1'b1;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (sts.sqrt_last)
                    state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd.roll_init = 1'b1;
                state_next    = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.cor_step = 1'b1;
                if (sts.cor_last)
                    state_next = S_PINIT;
            end
            S_PINIT:
            begin
                cmd.roll_done  = 1'b1;
                cmd.pitch_init = 1'b1;
                state_next     = S_PSTEP;
            end
            S_PSTEP:
            begin
                cmd.cor_step = 1'b1;
                if (sts.cor_last)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.pitch_done = 1'b1;
                state_next     = S_HOLD;
            end
            S_HOLD:
            begin
                // load result beat once, then wait until taken
                if (!ov_reg)
                begin
                    cmd.out_load = 1'b1;
                    ov_next      = 1'b1;
                end
                else if (!out_stall)
                begin
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ax_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ax_reg    <= ax_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

/* src/accel_tilt_angle_filter.sv */
// Per input beat with new data, the result follows filtering, the 30-step square root
// and two 16-step CORDIC passes; without new data a zeroed result is given. No new
// sample is taken until the result beat has been taken.
// Reset: asynchronous active low; clears filter state, weight and control.
// Top level of the accelerometer tilt-angle filter; depends on atf_pkg,
// atf_ctrl and atf_datapath.
module accel_tilt_angle_filter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         status,
    input  logic [15:0]        x_word,
    input  logic [15:0]        y_word,
    input  logic [15:0]        z_word,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               valid_res,
    output logic signed [21:0] filtered_x,
    output logic signed [21:0] filtered_y,
    output logic signed [21:0] filtered_z,
    output logic signed [15:0] roll_angle,
    output logic signed [14:0] pitch_angle
);
    import atf_pkg::*;

    logic [15:0] weight_reg;
    atf_cmd_t cmd;
    atf_sts_t sts;

    // hold the filter weight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            weight_reg <= '0;
        else if (cfg_we)
            weight_reg <= cfg_data;
    end

    atf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    atf_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .filter_weight (weight_reg),
        .status        (status),
        .x_word        (x_word),
        .y_word        (y_word),
        .z_word        (z_word),
        .cmd           (cmd),
        .sts           (sts),
        .o_valid_res   (valid_res),
        .o_fx          (filtered_x),
        .o_fy          (filtered_y),
        .o_fz          (filtered_z),
        .o_roll        (roll_angle),
        .o_pitch       (pitch_angle)
    );

    // no input beat taken while a result beat waits
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input taken while result pending");

    // result roll angle stays in range
    a_roll_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (roll_angle <= 16'sd23040 && roll_angle >= -16'sd23040))
        else $error("roll out of range");

    // a delivered beat drops valid
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> !out_valid)
        else $error("result repeated");

endmodule
